FILE: rtl/core/daily_lamp_event_scheduler_macros.svh
// Assertion macros shared by the lamp scheduler RTL.
// Users need clk and rst_n in scope; no other dependencies.
`ifndef DAILY_LAMP_EVENT_SCHEDULER_MACROS_SVH
`define DAILY_LAMP_EVENT_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define DLES_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dles assertion failed");
`define DLES_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dles assertion failed");
`define DLES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dles assertion failed");
`else
`define DLES_ASSERT_ALWAYS(lbl, expr)
`define DLES_ASSERT_IMPLIES(lbl, ante, cons)
`define DLES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/dles_pkg.sv
// Types, widths and helper functions for the lamp event scheduler.
// No dependencies.
package dles_pkg;

    localparam int ROW_W = 3;
    localparam int SLOT_IDX_W = 2;
    localparam int OBIT_W = 3;
    localparam int HOUR_W = 5;
    localparam int MINUTE_W = 6;
    localparam int DUR_W = 11;
    localparam int TIME_W = 12;
    localparam int MASK_W = 8;
    localparam int ACTIVE_W = 4;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic start;
        logic write;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } status_t;

    typedef struct packed {
        logic [OBIT_W-1:0]   output_bit;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [DUR_W-1:0]    duration;
    } slot_t;

    function automatic logic [TIME_W-1:0] time_of(input logic [HOUR_W-1:0] hour,
                                                  input logic [MINUTE_W-1:0] minute);
        logic [TIME_W-1:0] hx;
        hx = {{(TIME_W-HOUR_W){1'b0}}, hour};
        return (hx << 6) - (hx << 2) + {{(TIME_W-MINUTE_W){1'b0}}, minute};
    endfunction

endpackage

FILE: rtl/core/dles_ctrl.sv
// Sequencing state machine of the lamp scheduler.
// Depends on dles_pkg and the shared assertion macro header.
`include "daily_lamp_event_scheduler_macros.svh"

module dles_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              is_query,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dles_pkg::cmd_t    cmd,
    input  dles_pkg::status_t sts
);

    dles_pkg::state_t state_reg;
    dles_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign s_tready = (state_reg == dles_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.start    = 1'b0;
        cmd.write    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            dles_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    cmd.write  = !is_query;
                    state_next = is_query ? dles_pkg::ST_SCAN : dles_pkg::ST_DONE;
                end
            end
            dles_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = dles_pkg::ST_DRAIN;
                end
            end
            dles_pkg::ST_DRAIN:
            begin
                state_next = dles_pkg::ST_DONE;
            end
            dles_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = dles_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dles_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dles_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `DLES_ASSERT_NEXT(a_scan_to_drain, state_reg == dles_pkg::ST_SCAN && sts.scan_last,
        state_reg == dles_pkg::ST_DRAIN)
    `DLES_ASSERT_NEXT(a_accept_busy, accept, !s_tready)
    `DLES_ASSERT_IMPLIES(a_load_when_free, cmd.load_out, !out_valid_reg || m_tready)

endmodule

FILE: rtl/core/dles_datapath.sv
// Slot table, event walk and ranking datapath of the lamp scheduler.
// Depends on dles_pkg and the shared assertion macro header.
`include "daily_lamp_event_scheduler_macros.svh"

module dles_datapath
#(
    parameter int LAMP_COUNT     = 8,
    parameter int SLOTS_PER_LAMP = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dles_pkg::cmd_t                  cmd,
    output dles_pkg::status_t               sts,
    input  logic                            cfg_wr_en,
    input  logic [dles_pkg::ACTIVE_W-1:0]   cfg_wr_data,
    input  logic [dles_pkg::ROW_W-1:0]      lamp_row,
    input  logic [dles_pkg::SLOT_IDX_W-1:0] slot_index,
    input  logic [dles_pkg::OBIT_W-1:0]     output_bit,
    input  logic [dles_pkg::HOUR_W-1:0]     hour_value,
    input  logic [dles_pkg::MINUTE_W-1:0]   minute_value,
    input  logic [dles_pkg::DUR_W-1:0]      duration_minutes,
    output logic [dles_pkg::MASK_W-1:0]     lamp_mask,
    output logic                            next_valid,
    output logic [dles_pkg::TIME_W-1:0]     next_event_minute
);

    localparam int DEPTH = LAMP_COUNT * SLOTS_PER_LAMP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (LAMP_COUNT > 1) ? $clog2(LAMP_COUNT) : 1;
    localparam int SW    = (SLOTS_PER_LAMP > 1) ? $clog2(SLOTS_PER_LAMP) : 1;
    localparam int MW    = dles_pkg::MASK_W;
    localparam int TW    = dles_pkg::TIME_W;

    dles_pkg::slot_t                 slot_mem [DEPTH];
    logic [DEPTH-1:0]                slot_vld_reg;
    logic [dles_pkg::ACTIVE_W-1:0]   active_lamps_reg;

    logic [RW-1:0]                   row_cnt_reg;
    logic [RW-1:0]                   row_cnt_next;
    logic [SW-1:0]                   slot_cnt_reg;
    logic [SW-1:0]                   slot_cnt_next;
    logic                            phase_reg;
    logic                            phase_next;

    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   rd_addr;
    logic                            wr_in_range;

    dles_pkg::slot_t                 slot_rd_reg;
    logic                            vld_rd_reg;
    logic                            ev_valid_reg;
    logic                            ev_off_reg;
    logic                            ev_en_reg;

    logic [TW-1:0]                   q_reg;
    logic [MW-1:0]                   seen_reg;
    logic [MW-1:0]                   seen_next;
    logic [MW-1:0]                   lamp_on_reg;
    logic [MW-1:0]                   lamp_on_next;
    logic [TW-1:0]                   best_reg [MW];
    logic [TW-1:0]                   best_next [MW];
    logic                            nv_reg;
    logic                            nv_next;
    logic [TW-1:0]                   nm_reg;
    logic [TW-1:0]                   nm_next;

    logic                            ev_hit;
    logic [TW-1:0]                   ev_time;
    logic [dles_pkg::OBIT_W-1:0]     ev_bit;

    logic [MW-1:0]                   mask_out_reg;
    logic                            nv_out_reg;
    logic [TW-1:0]                   nm_out_reg;

    assign wr_in_range = (32'(lamp_row) < LAMP_COUNT) && (32'(slot_index) < SLOTS_PER_LAMP);
    assign wr_addr     = AW'(32'(lamp_row) * SLOTS_PER_LAMP + 32'(slot_index));
    assign rd_addr     = AW'(32'(row_cnt_reg) * SLOTS_PER_LAMP + 32'(slot_cnt_reg));

    assign sts.scan_last = (row_cnt_reg == RW'(LAMP_COUNT - 1)) && phase_reg
                           && (slot_cnt_reg == SW'(SLOTS_PER_LAMP - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_lamps_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            active_lamps_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            slot_mem[wr_addr] <= '{output_bit: output_bit, hour: hour_value,
                                   minute: minute_value, duration: duration_minutes};
        end
        if (cmd.step)
        begin
            slot_rd_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (cmd.write && wr_in_range)
        begin
            slot_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        row_cnt_next  = row_cnt_reg;
        slot_cnt_next = slot_cnt_reg;
        phase_next    = phase_reg;
        if (cmd.start)
        begin
            row_cnt_next  = '0;
            slot_cnt_next = '0;
            phase_next    = 1'b0;
        end
        else if (cmd.step)
        begin
            if (slot_cnt_reg == SW'(SLOTS_PER_LAMP - 1))
            begin
                slot_cnt_next = '0;
                phase_next    = !phase_reg;
                if (phase_reg)
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            else
            begin
                slot_cnt_next = slot_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            slot_cnt_reg <= '0;
            phase_reg    <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            row_cnt_reg  <= row_cnt_next;
            slot_cnt_reg <= slot_cnt_next;
            phase_reg    <= phase_next;
            ev_valid_reg <= cmd.step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            vld_rd_reg <= slot_vld_reg[rd_addr];
            ev_off_reg <= phase_reg;
            ev_en_reg  <= 32'(row_cnt_reg) < 32'(active_lamps_reg);
        end
        if (cmd.start)
        begin
            q_reg <= dles_pkg::time_of(hour_value, minute_value);
        end
    end

    assign ev_bit  = slot_rd_reg.output_bit;
    assign ev_time = dles_pkg::time_of(slot_rd_reg.hour, slot_rd_reg.minute)
                     + (ev_off_reg ? TW'(slot_rd_reg.duration) : '0);
    assign ev_hit  = ev_valid_reg && ev_en_reg && vld_rd_reg
                     && (slot_rd_reg.duration != '0);

    always_comb
    begin
        seen_next    = seen_reg;
        lamp_on_next = lamp_on_reg;
        best_next    = best_reg;
        nv_next      = nv_reg;
        nm_next      = nm_reg;
        if (cmd.start)
        begin
            seen_next    = '0;
            lamp_on_next = '0;
            nv_next      = 1'b0;
            nm_next      = '0;
        end
        else if (ev_hit)
        begin
            if (ev_time <= q_reg)
            begin
                if (!seen_reg[ev_bit] || (ev_time >= best_reg[ev_bit]))
                begin
                    seen_next[ev_bit]    = 1'b1;
                    lamp_on_next[ev_bit] = !ev_off_reg;
                    best_next[ev_bit]    = ev_time;
                end
            end
            else if (!nv_reg || (ev_time < nm_reg))
            begin
                nv_next = 1'b1;
                nm_next = ev_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            lamp_on_reg <= '0;
            nv_reg      <= 1'b0;
            nm_reg      <= '0;
        end
        else
        begin
            seen_reg    <= seen_next;
            lamp_on_reg <= lamp_on_next;
            nv_reg      <= nv_next;
            nm_reg      <= nm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (cmd.load_out)
        begin
            mask_out_reg <= seen_reg & lamp_on_reg;
            nv_out_reg   <= nv_reg;
            nm_out_reg   <= nm_reg;
        end
    end

    assign lamp_mask         = mask_out_reg;
    assign next_valid        = nv_out_reg;
    assign next_event_minute = nm_out_reg;

    `DLES_ASSERT_IMPLIES(a_nm_zero_without_next, !nv_reg, nm_reg == '0)
    `DLES_ASSERT_ALWAYS(a_on_needs_seen, (lamp_on_reg & ~seen_reg) == '0)
    `DLES_ASSERT_NEXT(a_step_marks_event, cmd.step, ev_valid_reg)

endmodule

FILE: rtl/core/daily_lamp_event_scheduler.sv
// Daily lamp event scheduler, top level. Depends on dles_pkg, dles_ctrl and dles_datapath.
//
// Requests arrive on the s_ stream. With s_tuser low, a request loads one timer slot
// (row, slot, output bit, start hour and minute, duration); with s_tuser high, it asks
// for the lamp mask and the next event time at the given hour and minute. Every request
// yields exactly one result on the m_ stream; a slot write returns an all-zero result.
// The active_lamps register is written through cfg_wr_en and cfg_wr_data, and the user
// must write it only while idle; the block does not enforce this. A slot write skips
// the walk. A query walks every slot twice, ON then OFF per row: the slot table has one
// read port and the walk ranks one ON or OFF event per cycle. One request is in work at
// a time; the next one is accepted as soon as the result sits in the output register.
// Reset clears the slot table valid bits, so every slot reads as disabled, and sets
// active_lamps to zero. When m_tready is low, the result holds in the output register
// and a finished request waits until that register frees up.
module daily_lamp_event_scheduler
#(
    parameter int LAMP_COUNT     = 8,
    parameter int SLOTS_PER_LAMP = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // lamp_row, slot_index, output_bit, hour_value, minute_value, duration_minutes, zero pad.
    input  logic [dles_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode.
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // lamp_mask, next_event_minute, zero pad.
    output logic [dles_pkg::M_TDATA_W-1:0]     m_tdata,
    // next_valid.
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [dles_pkg::ACTIVE_W-1:0]      cfg_wr_data
);

    dles_pkg::cmd_t                  cmd;
    dles_pkg::status_t               sts;
    logic [dles_pkg::MASK_W-1:0]     lamp_mask;
    logic [dles_pkg::TIME_W-1:0]     next_event_minute;

    dles_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .is_query (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    dles_datapath
    #(
        .LAMP_COUNT     (LAMP_COUNT),
        .SLOTS_PER_LAMP (SLOTS_PER_LAMP)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .lamp_row          (s_tdata[2:0]),
        .slot_index        (s_tdata[4:3]),
        .output_bit        (s_tdata[7:5]),
        .hour_value        (s_tdata[12:8]),
        .minute_value      (s_tdata[18:13]),
        .duration_minutes  (s_tdata[29:19]),
        .lamp_mask         (lamp_mask),
        .next_valid        (m_tuser),
        .next_event_minute (next_event_minute)
    );

    assign m_tdata = {4'b0000, next_event_minute, lamp_mask};

endmodule
